@@ src/qcbad_pkg.sv @@
package qcbad_pkg;

  // Field widths of one input word and one result word
  localparam int SAMPLE_W = 12;
  localparam int AVG_W    = 13;
  localparam int DIFF_W   = 14;
  localparam int CFG_W    = 11;
  localparam int NUM_CH   = 4;

  // Sample scale 3.3/2.55 taken as 22/17
  localparam int SCALE_NUM = 22;
  localparam int SCALE_DEN = 17;

  // Channel order inside a word
  localparam int CH_FR = 0;
  localparam int CH_FL = 1;
  localparam int CH_BR = 2;
  localparam int CH_BL = 3;

  typedef enum logic {
    OP_SCALE,
    OP_AVERAGE
  } lane_op_t;

  typedef struct packed {
    logic     start;
    lane_op_t op;
  } lane_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } lane_stat_t;

endpackage

@@ src/quad_channel_block_average_diff_core.sv @@
// Four-channel block averager. Each input word carries one reading per channel
// (front right, front left, back right, back left); every reading is scaled by
// 22/17 (truncating) and added to its channel total. When the count of words
// reaches window_length, one result word goes out with the four truncated
// averages and the signed left-minus-right differences for the front and back
// pairs, and totals and count start over. Each channel has its own lane. The
// 22/17 scaling is a multiply by a fixed reciprocal and a shift, so a word is
// scaled and added to its total in the cycle it is accepted; the next word
// is taken once the control has passed its scale state and returned to idle.
// At a window end each lane runs a restoring divider that yields one quotient
// bit per cycle over DW bits (DW = 24 with default parameters) to form
// total / window_length; the word that closes a window keeps the input closed
// through the averaging pass and the hand-off to the output register.
// The output register lets the next windows run while a result waits to be
// taken; the block only stalls at a window end if the previous result is still
// unread. A window_length write of 0 is stored as 1, a write above MAX_WINDOW
// as MAX_WINDOW; shortening the window mid-run closes it on the next word.
module quad_channel_block_average_diff_core
  import qcbad_pkg::*;
#(
  parameter int MAX_WINDOW  = 1024,
  parameter int SAMPLE_BITS = 12
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // cfg_data: window_length
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [CFG_W-1:0]                 cfg_data,
  // in_tdata: front_right_sample, front_left_sample, back_right_sample,
  //           back_left_sample (12 bits each, lowest first)
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [NUM_CH*SAMPLE_W-1:0]       in_tdata,
  // out_tdata: front_right_average, front_left_average, back_right_average,
  //            back_left_average (13 bits each), front_difference,
  //            back_difference (14 bits signed each), lowest first
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [NUM_CH*AVG_W+2*DIFF_W-1:0] out_tdata
);

  // Window storage covers the reset value 16 even for a small MAX_WINDOW
  localparam int WIN_MAX_L  = (MAX_WINDOW > 16) ? MAX_WINDOW : 16;
  localparam int WIN_W      = $clog2(WIN_MAX_L + 1);
  localparam int DVW        = (WIN_W > 5) ? WIN_W : 5;
  localparam int TOT_W      = SAMPLE_BITS + 1 + WIN_W;
  localparam int DW_A       = (TOT_W > SAMPLE_BITS + 5) ? TOT_W : SAMPLE_BITS + 5;
  localparam int DW         = (DW_A > DIFF_W) ? DW_A : DIFF_W;
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(16);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCALE,
    S_AVG,
    S_PUSH
  } state_t;

  state_t           state_r;
  logic [WIN_W-1:0] win_r;
  logic [WIN_W-1:0] win_nxt;
  logic [WIN_W-1:0] cnt_r;

  lane_ctrl_t       lane_ctrl;
  lane_stat_t       lane_stat [NUM_CH];
  logic [DW-1:0]    lane_quot [NUM_CH];
  logic             all_done;
  logic             in_accept;
  logic             window_hit;
  logic             merge_ready;
  logic             capture;

  // Clamp the written window length into 1..MAX_WINDOW
  always_comb begin
    if (cfg_data == '0) begin
      win_nxt = WIN_W'(1);
    end else if (32'(cfg_data) > 32'(MAX_WINDOW)) begin
      win_nxt = WIN_W'(MAX_WINDOW);
    end else begin
      win_nxt = WIN_W'(cfg_data);
    end
  end

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign window_hit = (cnt_r >= win_r);

  always_comb begin
    all_done = 1'b1;
    for (int i = 0; i < NUM_CH; i++) begin
      all_done = all_done && lane_stat[i].done && !lane_stat[i].busy;
    end
  end

  // Scale and accumulate an accepted word, start the averaging pass at a window end
  always_comb begin
    lane_ctrl.start = in_accept || ((state_r == S_SCALE) && all_done && window_hit);
    lane_ctrl.op    = in_accept ? OP_SCALE : OP_AVERAGE;
  end

  assign capture = (state_r == S_PUSH) && merge_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      win_r   <= WIN_RESET;
      cnt_r   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        win_r <= win_nxt;
      end
      case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            cnt_r   <= cnt_r + 1'b1;
            state_r <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (all_done) begin
            if (window_hit) begin
              cnt_r   <= '0;
              state_r <= S_AVG;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_AVG: begin
          if (all_done) begin
            state_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          // hold the quotients in the lanes until the output register frees up
          if (merge_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
    qcbad_lane #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .DW         (DW),
      .DVW        (DVW),
      .TOT_W      (TOT_W)
    ) u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (lane_ctrl),
      .sample  (in_tdata[g*SAMPLE_W +: SAMPLE_W]),
      .window  (DVW'(win_r)),
      .stat    (lane_stat[g]),
      .quotient(lane_quot[g])
    );
  end

  qcbad_merge #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .DW         (DW)
  ) u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .capture   (capture),
    .quot      (lane_quot),
    .ready     (merge_ready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule

@@ src/qcbad_lane.sv @@
module qcbad_lane
  import qcbad_pkg::*;
#(
  parameter int SAMPLE_BITS = 12,
  parameter int DW          = 24,
  parameter int DVW         = 11,
  parameter int TOT_W       = 24
) (
  input  logic                clk,
  input  logic                rst_n,
  input  lane_ctrl_t          ctrl,
  input  logic [SAMPLE_W-1:0] sample,
  input  logic [DVW-1:0]      window,
  output lane_stat_t          stat,
  output logic [DW-1:0]       quotient
);

  localparam int SCALED_W = SAMPLE_BITS + 1;
  localparam int STEP_W   = $clog2(DW);
  // floor(raw * 22 / 17) as (raw * 22 * M) >> RECIP_SH with M = ceil(2^RECIP_SH / 17);
  // exact for every raw * 22 below 2^(SAMPLE_BITS + 5)
  localparam int     RECIP_SH = SAMPLE_BITS + 10;
  localparam longint RECIP_M  = ((longint'(1) << RECIP_SH) + SCALE_DEN - 1) / SCALE_DEN;
  localparam int     PROD_W   = 2 * SAMPLE_BITS + 15;
  localparam logic [PROD_W-1:0] SCALE_MUL = PROD_W'(longint'(SCALE_NUM) * RECIP_M);

  logic [15:0]            sample_ext;
  logic [SAMPLE_BITS-1:0] raw;
  logic [PROD_W-1:0]      scale_prod;
  logic [SCALED_W-1:0]    scaled;

  logic                   busy_r;
  logic                   done_r;
  logic [STEP_W-1:0]      step_r;
  logic [DVW-1:0]         den_r;
  logic [DVW-1:0]         rem_r;
  logic [DW-1:0]          quo_r;
  logic [TOT_W-1:0]       total_r;

  logic [DVW:0]           trial;
  logic                   q_bit;
  logic [DVW-1:0]         rem_nxt;
  logic [DW-1:0]          quo_nxt;
  logic                   last_step;

  // Drop sample bits above SAMPLE_BITS, then scale by the fixed reciprocal
  assign sample_ext = 16'(sample);
  assign raw        = sample_ext[SAMPLE_BITS-1:0];
  assign scale_prod = PROD_W'(raw) * SCALE_MUL;
  assign scaled     = scale_prod[RECIP_SH +: SCALED_W];

  // One restoring divide step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_r, quo_r[DW-1]};
    q_bit = (trial >= {1'b0, den_r});
    if (q_bit) begin
      rem_nxt = DVW'(trial - {1'b0, den_r});
    end else begin
      rem_nxt = trial[DVW-1:0];
    end
    quo_nxt = {quo_r[DW-2:0], q_bit};
  end

  assign last_step = (step_r == STEP_W'(DW - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      total_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.start) begin
        if (ctrl.op == OP_SCALE) begin
          // scale and accumulate in the accepting cycle
          done_r  <= 1'b1;
          total_r <= total_r + TOT_W'(scaled);
        end else begin
          busy_r <= 1'b1;
          step_r <= '0;
          rem_r  <= '0;
          quo_r  <= DW'(total_r);
          den_r  <= window;
        end
      end else if (busy_r) begin
        rem_r  <= rem_nxt;
        quo_r  <= quo_nxt;
        step_r <= step_r + 1'b1;
        if (last_step) begin
          busy_r  <= 1'b0;
          done_r  <= 1'b1;
          // clear once the average is out
          total_r <= '0;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

@@ src/qcbad_merge.sv @@
module qcbad_merge
  import qcbad_pkg::*;
#(
  parameter int SAMPLE_BITS = 12,
  parameter int DW          = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 capture,
  input  logic [DW-1:0]                        quot [NUM_CH],
  output logic                                 ready,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [NUM_CH*AVG_W+2*DIFF_W-1:0]     out_tdata
);

  localparam int        AVG_MAX_I = ((2 ** SAMPLE_BITS - 1) * SCALE_NUM) / SCALE_DEN;
  localparam logic [DW-1:0] AVG_MAX = DW'(AVG_MAX_I);
  localparam int        OUT_W     = NUM_CH * AVG_W + 2 * DIFF_W;

  logic [DW-1:0]    sat [NUM_CH];
  logic [DW-1:0]    front_diff;
  logic [DW-1:0]    back_diff;
  logic [OUT_W-1:0] data_nxt;
  logic [OUT_W-1:0] data_r;
  logic             valid_r;

  // Clamp averages that only a shortened window can push past full scale
  always_comb begin
    for (int i = 0; i < NUM_CH; i++) begin
      sat[i] = (quot[i] > AVG_MAX) ? AVG_MAX : quot[i];
    end
    front_diff = sat[CH_FL] - sat[CH_FR];
    back_diff  = sat[CH_BL] - sat[CH_BR];
    data_nxt   = {back_diff[DIFF_W-1:0], front_diff[DIFF_W-1:0],
                  sat[CH_BL][AVG_W-1:0], sat[CH_BR][AVG_W-1:0],
                  sat[CH_FL][AVG_W-1:0], sat[CH_FR][AVG_W-1:0]};
  end

  assign ready = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      if (capture) begin
        valid_r <= 1'b1;
        data_r  <= data_nxt;
      end else if (out_tready) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

@@ test/quad_channel_block_average_diff_core_tb.sv @@
`timescale 1ns / 1ps

module quad_channel_block_average_diff_core_tb;
  import qcbad_pkg::*;

  localparam int MAX_WIN       = 1024;
  // Largest scaled reading; an average past it only follows a shortened window
  localparam int AVG_CEIL      = ((2**SAMPLE_W - 1) * SCALE_NUM) / SCALE_DEN;
  // Per-word work plus the averaging pass and output hand-off, with margin
  localparam int SETTLE_CYCLES = 100;
  localparam int QUIET_LIMIT   = 4000;

  // One input word: index by CH_* constant, front right in the lowest bits
  typedef logic [NUM_CH-1:0][SAMPLE_W-1:0] sample_set_t;

  // One result word, laid out to match out_tdata (front right average lowest)
  typedef struct packed {
    logic signed [DIFF_W-1:0]       back_diff;
    logic signed [DIFF_W-1:0]       front_diff;
    logic [NUM_CH-1:0][AVG_W-1:0]   avg;
  } window_result_t;

  typedef enum {
    ROW_WINDOW,
    ROW_WORD
  } row_kind_t;

  typedef struct {
    row_kind_t       kind;
    logic [CFG_W-1:0] win;
    sample_set_t     smp;
    bit              typed;
    window_result_t  res;
  } stim_row_t;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_W-1:0] cfg_data;
  logic in_tvalid;
  logic in_tready;
  // in_tdata: front_right_sample, front_left_sample, back_right_sample,
  //           back_left_sample (lowest first)
  logic [NUM_CH*SAMPLE_W-1:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  // out_tdata: front_right_average, front_left_average, back_right_average,
  //            back_left_average, front_difference, back_difference (lowest first)
  logic [NUM_CH*AVG_W+2*DIFF_W-1:0] out_tdata;

  // Shadow of the block: window setting, word count and channel totals
  int win_len;
  int set_count;
  int ch_total [NUM_CH];

  window_result_t expected_windows [$];
  stim_row_t      plan [$];
  int             mismatch_count;
  int             tx_gap_pct;
  int             rx_stall_pct;
  int             quiet_cycles;

  string ch_name [NUM_CH] = '{"front right", "front left", "back right", "back left"};

  quad_channel_block_average_diff_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Clamp a window write the way the register stores it
  function automatic void store_window(input logic [CFG_W-1:0] v);
    int x;
    x = int'(v);
    if (x == 0) x = 1;
    if (x > MAX_WIN) x = MAX_WIN;
    win_len = x;
  endfunction

  // Add one scaled word to the totals; on a completed window, produce the averages
  function automatic bit accumulate_set(input sample_set_t w, output window_result_t r);
    int av [NUM_CH];
    r = '0;
    for (int c = 0; c < NUM_CH; c++) begin
      ch_total[c] += (int'(w[c]) * SCALE_NUM) / SCALE_DEN;
    end
    set_count++;
    if (set_count < win_len) return 1'b0;
    for (int c = 0; c < NUM_CH; c++) begin
      av[c] = ch_total[c] / win_len;
      if (av[c] > AVG_CEIL) av[c] = AVG_CEIL;
      r.avg[c] = AVG_W'(av[c]);
      ch_total[c] = 0;
    end
    set_count = 0;
    r.front_diff = DIFF_W'(av[CH_FL] - av[CH_FR]);
    r.back_diff  = DIFF_W'(av[CH_BL] - av[CH_BR]);
    return 1'b1;
  endfunction

  function automatic sample_set_t set_of(input int fr, input int fl, input int br,
                                         input int bl);
    sample_set_t s;
    s[CH_FR] = SAMPLE_W'(fr);
    s[CH_FL] = SAMPLE_W'(fl);
    s[CH_BR] = SAMPLE_W'(br);
    s[CH_BL] = SAMPLE_W'(bl);
    return s;
  endfunction

  function automatic window_result_t make_result(input int fr, input int fl, input int br,
                                                 input int bl, input int fd, input int bd);
    window_result_t r;
    r.avg[CH_FR] = AVG_W'(fr);
    r.avg[CH_FL] = AVG_W'(fl);
    r.avg[CH_BR] = AVG_W'(br);
    r.avg[CH_BL] = AVG_W'(bl);
    r.front_diff = DIFF_W'(fd);
    r.back_diff  = DIFF_W'(bd);
    return r;
  endfunction

  task automatic add_window(input logic [CFG_W-1:0] v);
    stim_row_t row;
    row = '{kind: ROW_WINDOW, win: v, smp: '0, typed: 1'b0, res: '0};
    plan.push_back(row);
  endtask

  task automatic add_word(input sample_set_t s, input bit typed, input window_result_t r);
    stim_row_t row;
    row = '{kind: ROW_WORD, win: '0, smp: s, typed: typed, res: r};
    plan.push_back(row);
  endtask

  // Present one word at the falling edge; idle the sender a cycle at a time
  // at the rate set by the current idling regime
  task automatic send_word(input sample_set_t w);
    @(negedge clk);
    while ($urandom_range(0, 99) < tx_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
  endtask

  // Drop valid, wait until every expected result is out, then let the block settle
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_windows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the window register while the block is idle
  task automatic write_window(input logic [CFG_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    store_window(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: stall at random, rate set by the current idling regime
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // Check each accepted result word against the oldest expectation
  always @(posedge clk) begin : check_results
    window_result_t got;
    window_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_windows.size() == 0) begin
        report_mismatch($sformatf("result word with none expected: %h", out_tdata));
      end else begin
        want = expected_windows.pop_front();
        for (int c = 0; c < NUM_CH; c++) begin
          if (got.avg[c] !== want.avg[c])
            report_mismatch($sformatf("%s average: got %0d, want %0d",
                                      ch_name[c], got.avg[c], want.avg[c]));
        end
        if (got.front_diff !== want.front_diff)
          report_mismatch($sformatf("front difference: got %0d, want %0d",
                                    got.front_diff, want.front_diff));
        if (got.back_diff !== want.back_diff)
          report_mismatch($sformatf("back difference: got %0d, want %0d",
                                    got.back_diff, want.back_diff));
      end
    end
  end

  // Watchdog: end the run after too many cycles with no word moving anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    stim_row_t      row;
    window_result_t r;
    sample_set_t    w;
    bit             produced;
    int             n_words;
    logic [CFG_W-1:0] v;

    // Hold every input at a known value from time zero
    rst_n        = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    out_tready   = 1'b0;
    tx_gap_pct   = 14;
    rx_stall_pct = 62;
    win_len      = 16;
    set_count    = 0;
    for (int c = 0; c < NUM_CH; c++) ch_total[c] = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table. Window of one: every word closes a window, so the
    // extremes and the truncating scale show up directly.
    add_window(1);
    add_word(set_of(0, 0, 0, 0), 1'b1, make_result(0, 0, 0, 0, 0, 0));
    add_word(set_of(4095, 4095, 4095, 4095), 1'b1,
             make_result(5299, 5299, 5299, 5299, 0, 0));
    add_word(set_of(0, 4095, 4095, 0), 1'b1, make_result(0, 5299, 5299, 0, 5299, -5299));
    add_word(set_of(4095, 0, 0, 4095), 1'b1, make_result(5299, 0, 0, 5299, -5299, 5299));
    add_word(set_of('h555, 'hAAA, 'hAAA, 'h555), 1'b0, '0);
    // Zero window write stores one; 17, 16, 1, 34 scale to 22, 20, 1, 44
    add_window(0);
    add_word(set_of(17, 16, 1, 34), 1'b1, make_result(22, 20, 1, 44, -2, 43));
    // Oversized write clamps to the largest window; shorten it mid-window so the
    // next word closes it and the averages saturate
    add_window(2047);
    repeat (4) add_word(set_of(4095, 0, 0, 4095), 1'b0, '0);
    add_window(2);
    add_word(set_of(4095, 0, 0, 4095), 1'b1, make_result(5299, 0, 0, 5299, -5299, 5299));
    add_word(set_of(100, 200, 3000, 4000), 1'b0, '0);
    add_word(set_of(1, 2, 3, 4), 1'b0, '0);
    add_window(3);
    add_word(set_of(2048, 2047, 1024, 3071), 1'b0, '0);
    add_word(set_of(13, 4094, 777, 1), 1'b0, '0);
    add_word(set_of(3333, 5, 2222, 4000), 1'b0, '0);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_WINDOW) begin
        write_window(row.win);
      end else begin
        send_word(row.smp);
        produced = accumulate_set(row.smp, r);
        if (row.typed) expected_windows.push_back(row.res);
        else if (produced) expected_windows.push_back(r);
      end
    end

    // Random phases: sender mostly busy then mostly idle, then no idling at all;
    // the last phase sends as many words as the largest window length
    for (int p = 0; p < 10; p++) begin
      if (p == 3) begin
        tx_gap_pct   = 62;
        rx_stall_pct = 14;
      end else if (p == 6) begin
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
      end
      if (p == 9) begin
        v       = CFG_W'(MAX_WIN);
        n_words = MAX_WIN;
      end else begin
        case ($urandom_range(0, 9))
          0:       v = '0;
          1:       v = CFG_W'(1);
          8:       v = CFG_W'($urandom_range(9, 40));
          9:       v = CFG_W'($urandom_range(MAX_WIN + 1, 2**CFG_W - 1));
          default: v = CFG_W'($urandom_range(2, 8));
        endcase
        n_words = $urandom_range(4, 12);
      end
      write_window(v);
      repeat (n_words) begin
        for (int c = 0; c < NUM_CH; c++) begin
          case ($urandom_range(0, 9))
            0:       w[c] = '0;
            1:       w[c] = '1;
            default: w[c] = SAMPLE_W'($urandom_range(0, 2**SAMPLE_W - 1));
          endcase
        end
        send_word(w);
        if (accumulate_set(w, r)) expected_windows.push_back(r);
      end
    end

    drain();
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/qcbad_pkg.sv
src/qcbad_lane.sv
src/qcbad_merge.sv
src/quad_channel_block_average_diff_core.sv
test/quad_channel_block_average_diff_core_tb.sv
